FILE: hdl/bdhr_pkg.sv
// Package for the button debouncer: command, event, navigation and register codes,
// reset values of the timing registers and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package bdhr_pkg;

   localparam int TIME_W = 32;
   localparam int CFG_W  = 16;
   localparam int PINS   = 4;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_READ = 2'd1,
      CMD_NAV  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PRESS   = 3'd1,
      EV_RELEASE = 3'd2,
      EV_HOLD    = 3'd3,
      EV_REPEAT  = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ACT_IDLE   = 3'd0,
      ACT_SELECT = 3'd1,
      ACT_BACK   = 3'd2,
      ACT_UP     = 3'd3,
      ACT_DOWN   = 3'd4
   } nav_type;

   typedef enum logic [2:0] {
      CSR_DEBOUNCE  = 3'd0,
      CSR_HOLD      = 3'd1,
      CSR_REPEAT    = 3'd2,
      CSR_FAST      = 3'd3,
      CSR_ACCEL     = 3'd4
   } csr_idx_type;

   // Button positions used by the navigation query.
   localparam int KEY_UP     = 0;
   localparam int KEY_DOWN   = 1;
   localparam int KEY_SELECT = 2;
   localparam int KEY_BACK   = 3;

   localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
   localparam logic [CFG_W-1:0] HOLD_RST     = 16'd500;
   localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd120;
   localparam logic [CFG_W-1:0] FAST_RST     = 16'd60;
   localparam logic [CFG_W-1:0] ACCEL_RST    = 16'd2000;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_time;
      logic [CFG_W-1:0] hold_time;
      logic [CFG_W-1:0] repeat_interval;
      logic [CFG_W-1:0] fast_repeat_interval;
      logic [CFG_W-1:0] accelerate_after;
   } cfg_type;

   // Per-button command for one processed word.
   typedef struct packed {
      logic              tick;
      logic              clear;
      logic              raw;
      logic [TIME_W-1:0] now;
   } lane_cmd_type;

endpackage

FILE: hdl/bdhr_if.sv
// Valid/ready channel interfaces for the request and response words.
// Field widths are written out directly; no dependency on bdhr_pkg.
`timescale 1ns / 1ps

interface bdhr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] timestamp;
   logic [3:0]  raw_levels;
   logic [1:0]  button_index;

   modport source (output valid, command, timestamp, raw_levels, button_index,
                   input ready);
   modport sink   (input valid, command, timestamp, raw_levels, button_index,
                   output ready);
endinterface

interface bdhr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_code;
   logic [2:0] nav_action;
   logic [3:0] pressed_mask;

   modport source (output valid, event_code, nav_action, pressed_mask, input ready);
   modport sink   (input valid, event_code, nav_action, pressed_mask, output ready);
endinterface

FILE: hdl/bdhr_csr.sv
// Timing configuration registers written through the plain write port.
// Depends on bdhr_pkg.
`timescale 1ns / 1ps

module bdhr_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [15:0]             csr_wdata,
   output bdhr_pkg::cfg_type       cfg
);
   import bdhr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Decode the register index; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_DEBOUNCE: cfg_in.debounce_time        = csr_wdata;
            CSR_HOLD:     cfg_in.hold_time            = csr_wdata;
            CSR_REPEAT:   cfg_in.repeat_interval      = csr_wdata;
            CSR_FAST:     cfg_in.fast_repeat_interval = csr_wdata;
            CSR_ACCEL:    cfg_in.accelerate_after     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time        <= DEBOUNCE_RST;
         cfg_ff.hold_time            <= HOLD_RST;
         cfg_ff.repeat_interval      <= REPEAT_RST;
         cfg_ff.fast_repeat_interval <= FAST_RST;
         cfg_ff.accelerate_after     <= ACCEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/bdhr_lane.sv
// State and update logic of one button: debounce, hold and auto-repeat timing
// and the latched event. Depends on bdhr_pkg.
`timescale 1ns / 1ps

module bdhr_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  bdhr_pkg::cfg_type       cfg,
   input  bdhr_pkg::lane_cmd_type  cmd,
   output bdhr_pkg::event_type     event_now,
   output logic                    stable_next
);
   import bdhr_pkg::*;

   logic              last_raw_ff, last_raw_in;
   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] change_ff, change_in;
   logic [TIME_W-1:0] press_ff, press_in;
   logic [TIME_W-1:0] repeat_ff, repeat_in;
   event_type         event_ff, event_in;
   logic              hold_seen_ff, hold_seen_in;

   logic [TIME_W-1:0] since_change, since_press, since_repeat;
   logic [CFG_W-1:0]  interval;
   logic              settled, flip, pressed_on, held;

   // Elapsed times, modulo 2^32.
   assign since_change = cmd.now - change_ff;
   assign since_press  = cmd.now - press_ff;
   assign since_repeat = cmd.now - repeat_ff;

   // A level that just changed has zero age, so it can never settle this tick.
   assign settled    = (cmd.raw == last_raw_ff) &&
                       (since_change > {16'd0, cfg.debounce_time});
   assign flip       = settled && (cmd.raw != stable_ff);
   assign pressed_on = flip && !cmd.raw;
   // A fresh press has zero hold age; otherwise the button must stay pressed.
   assign held       = !pressed_on && !stable_ff && flip == 1'b0 &&
                       (since_press > {16'd0, cfg.hold_time});
   assign interval   = (since_press > {16'd0, cfg.accelerate_after}) ?
                       cfg.fast_repeat_interval : cfg.repeat_interval;

   always_comb begin
      last_raw_in  = last_raw_ff;
      stable_in    = stable_ff;
      change_in    = change_ff;
      press_in     = press_ff;
      repeat_in    = repeat_ff;
      event_in     = event_ff;
      hold_seen_in = hold_seen_ff;
      if (cmd.tick) begin
         if (cmd.raw != last_raw_ff) begin
            last_raw_in = cmd.raw;
            change_in   = cmd.now;
         end
         if (flip) begin
            stable_in = cmd.raw;
            if (!cmd.raw) begin
               event_in     = EV_PRESS;
               press_in     = cmd.now;
               hold_seen_in = 1'b0;
            end else begin
               event_in = EV_RELEASE;
            end
         end
         // Hold fires once; the repeat timer restarts at the hold, so no repeat
         // can follow in the same tick.
         if (held) begin
            if (!hold_seen_ff) begin
               event_in     = EV_HOLD;
               hold_seen_in = 1'b1;
               repeat_in    = cmd.now;
            end else if (since_repeat > {16'd0, interval}) begin
               event_in  = EV_REPEAT;
               repeat_in = cmd.now;
            end
         end
      end else if (cmd.clear) begin
         event_in = EV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff  <= 1'b1;
         stable_ff    <= 1'b1;
         change_ff    <= '0;
         press_ff     <= '0;
         repeat_ff    <= '0;
         event_ff     <= EV_NONE;
         hold_seen_ff <= 1'b0;
      end else begin
         last_raw_ff  <= last_raw_in;
         stable_ff    <= stable_in;
         change_ff    <= change_in;
         press_ff     <= press_in;
         repeat_ff    <= repeat_in;
         event_ff     <= event_in;
         hold_seen_ff <= hold_seen_in;
      end
   end

   assign event_now   = event_ff;
   assign stable_next = stable_in;

   // A debounced press always leaves a press event behind.
   a_press_latched: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick && stable_ff && !stable_in) |=> (event_ff == EV_PRESS))
      else $error("debounced press did not latch a press event");

   // A clear never coincides with a sample.
   a_tick_clear_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.tick && cmd.clear))
      else $error("tick and clear issued together");

endmodule

FILE: hdl/button_debounce_hold_repeat.sv
// Top level of the four-button debouncer with hold and auto-repeat.
// Depends on bdhr_pkg, bdhr_if, bdhr_csr and bdhr_lane.
//
// Usage:
//   req_ch carries one request word: command (tick, read, nav), timestamp in
//   milliseconds, active-low raw levels and a button index. rsp_ch returns
//   exactly one word per request: event_code for a read, nav_action for a nav
//   query, and the debounced pressed mask after the request took effect.
//   Timing registers are written on csr_we/csr_index/csr_wdata; the user must
//   write them only while idle; the block itself does not enforce this.
// Pipeline and throughput:
//   A request is captured in the input register at the accepting edge and is
//   processed by the per-button subtract-and-compare logic once the result
//   register is free or being drained; that edge loads the result register
//   and lane state. One request per cycle is sustained with rsp_ch.ready high.
// Reset:
//   All buttons read released with no event; the timing registers return to
//   20, 500, 120, 60 and 2000 ms. Both registers come up empty.
// Stalls:
//   While rsp_ch is held off the result register keeps its word, and one more
//   request can still be taken into the input register before req_ch.ready
//   drops.
`timescale 1ns / 1ps

module button_debounce_hold_repeat #(
   parameter int BUTTONS = 4
) (
   input  logic        clock,
   input  logic        reset,
   bdhr_req_if.sink    req_ch,
   bdhr_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bdhr_pkg::*;

   cfg_type cfg;

   // Input register.
   logic              stage_vld_ff, stage_vld_in;
   logic [1:0]        stage_cmd_ff;
   logic [TIME_W-1:0] stage_time_ff;
   logic [PINS-1:0]   stage_raw_ff;
   logic [1:0]        stage_idx_ff;

   // Result register.
   logic              rsp_vld_ff, rsp_vld_in;
   event_type         rsp_ev_ff;
   nav_type           rsp_nav_ff;
   logic [PINS-1:0]   rsp_mask_ff;

   logic              take, go;
   logic              is_tick;
   event_type         lane_ev [BUTTONS];
   logic [BUTTONS-1:0] lane_stable;
   logic [BUTTONS-1:0] lane_clr;
   event_type         ev4 [PINS];
   logic [PINS-1:0]   clr4;
   event_type         ev_res;
   nav_type           nav_res;
   logic [PINS-1:0]   mask_res;

   bdhr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: process when the result register is free or being drained.
   assign go           = stage_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !stage_vld_ff || go;
   assign take         = req_ch.valid && req_ch.ready;
   assign stage_vld_in = take ? 1'b1 : (go ? 1'b0 : stage_vld_ff);
   assign rsp_vld_in   = go ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_vld_ff);
   assign is_tick      = go && (cmd_type'(stage_cmd_ff) == CMD_TICK);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_cmd_ff  <= req_ch.command;
         stage_time_ff <= req_ch.timestamp;
         stage_raw_ff  <= req_ch.raw_levels;
         stage_idx_ff  <= req_ch.button_index;
      end
      if (go) begin
         rsp_ev_ff   <= ev_res;
         rsp_nav_ff  <= nav_res;
         rsp_mask_ff <= mask_res;
      end
   end

   // One lane per button; buttons beyond the raw pins read as released.
   for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
      lane_cmd_type lcmd;
      logic         raw_bit;
      if (b < PINS) begin : g_pin
         assign raw_bit     = stage_raw_ff[b];
         assign lane_clr[b] = clr4[b];
      end else begin : g_nopin
         assign raw_bit     = 1'b1;
         assign lane_clr[b] = 1'b0;
      end
      assign lcmd = {is_tick, lane_clr[b], raw_bit, stage_time_ff};

      bdhr_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .cfg         (cfg),
         .cmd         (lcmd),
         .event_now   (lane_ev[b]),
         .stable_next (lane_stable[b])
      );
   end

   // Missing buttons present no event and no pressed bit.
   for (genvar i = 0; i < PINS; i++) begin : g_pad
      if (i < BUTTONS) begin : g_have
         assign ev4[i]      = lane_ev[i];
         assign mask_res[i] = !lane_stable[i];
      end else begin : g_none
         assign ev4[i]      = EV_NONE;
         assign mask_res[i] = 1'b0;
      end
   end

   // Read and navigation decode; every event that is inspected is cleared.
   always_comb begin
      ev_res  = EV_NONE;
      nav_res = ACT_IDLE;
      clr4    = '0;
      if (go) begin
         unique case (cmd_type'(stage_cmd_ff))
            CMD_READ: begin
               ev_res             = ev4[stage_idx_ff];
               clr4[stage_idx_ff] = 1'b1;
            end
            CMD_NAV: begin
               clr4[KEY_SELECT] = 1'b1;
               if (ev4[KEY_SELECT] == EV_PRESS) begin
                  nav_res = ACT_SELECT;
               end else begin
                  clr4[KEY_BACK] = 1'b1;
                  if (ev4[KEY_BACK] == EV_PRESS) begin
                     nav_res = ACT_BACK;
                  end else begin
                     clr4[KEY_UP] = 1'b1;
                     if (ev4[KEY_UP] == EV_PRESS || ev4[KEY_UP] == EV_REPEAT) begin
                        nav_res = ACT_UP;
                     end else begin
                        clr4[KEY_DOWN] = 1'b1;
                        if (ev4[KEY_DOWN] == EV_PRESS ||
                            ev4[KEY_DOWN] == EV_REPEAT) begin
                           nav_res = ACT_DOWN;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.event_code   = rsp_ev_ff;
   assign rsp_ch.nav_action   = rsp_nav_ff;
   assign rsp_ch.pressed_mask = rsp_mask_ff;

   // A navigation answer only comes from a navigation query.
   a_nav_only_on_nav: assert property (@(posedge clock) disable iff (reset)
      (go && nav_res != ACT_IDLE) |-> (cmd_type'(stage_cmd_ff) == CMD_NAV))
      else $error("navigation answer from a non-navigation word");

   // The request side is only held off when both registers are occupied.
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (stage_vld_ff && rsp_vld_ff))
      else $error("request held off with a free register");

   // Every processed word lands in the result register.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_vld_ff)
      else $error("processed word was not registered as a result");

endmodule

FILE: dv/bdhr_tb_pkg.sv
// Scoreboard for the button debouncer testbench: a cycle-free predictor of the
// per-button debounce, hold and repeat logic plus the queue of expected words.
// Depends on bdhr_pkg for codes, widths and reset values of the timing registers.
`timescale 1ns / 1ps

package bdhr_tb_pkg;

   import bdhr_pkg::*;

   // The command field has one code the block does not use.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      event_type  ev;
      nav_type    nav;
      logic [3:0] mask;
   } button_rsp_type;

   class debounce_scoreboard_type;
      logic [31:0]    settle_ms;
      logic [31:0]    hold_ms;
      logic [31:0]    slow_ms;
      logic [31:0]    fast_ms;
      logic [31:0]    accel_ms;
      logic           last_raw   [PINS];
      logic           stable_lvl [PINS];
      logic [31:0]    change_at  [PINS];
      logic [31:0]    press_at   [PINS];
      logic [31:0]    repeat_at  [PINS];
      event_type      latched    [PINS];
      logic           hold_done  [PINS];
      button_rsp_type pending_responses [$];
      int             errors;

      function new();
         settle_ms = {16'd0, DEBOUNCE_RST};
         hold_ms   = {16'd0, HOLD_RST};
         slow_ms   = {16'd0, REPEAT_RST};
         fast_ms   = {16'd0, FAST_RST};
         accel_ms  = {16'd0, ACCEL_RST};
         for (int b = 0; b < PINS; b++) begin
            last_raw[b]   = 1'b1;
            stable_lvl[b] = 1'b1;
            change_at[b]  = '0;
            press_at[b]   = '0;
            repeat_at[b]  = '0;
            latched[b]    = EV_NONE;
            hold_done[b]  = 1'b0;
         end
         errors = 0;
      endfunction

      function void write_config(logic [2:0] index, logic [15:0] value);
         case (index)
            CSR_DEBOUNCE: settle_ms = {16'd0, value};
            CSR_HOLD:     hold_ms   = {16'd0, value};
            CSR_REPEAT:   slow_ms   = {16'd0, value};
            CSR_FAST:     fast_ms   = {16'd0, value};
            CSR_ACCEL:    accel_ms  = {16'd0, value};
            default: ;
         endcase
      endfunction

      function event_type take_event(int b);
         event_type e;
         e = latched[b];
         latched[b] = EV_NONE;
         return e;
      endfunction

      // One millisecond sample of the raw pins; all time differences wrap at 2^32.
      function void sample_tick(logic [31:0] now, logic [3:0] levels);
         logic [31:0] interval;
         for (int b = 0; b < PINS; b++) begin
            if (levels[b] != last_raw[b]) begin
               last_raw[b]  = levels[b];
               change_at[b] = now;
            end
            // A level that has outlasted the debounce time is taken as the new state.
            if ((now - change_at[b]) > settle_ms && levels[b] != stable_lvl[b]) begin
               stable_lvl[b] = levels[b];
               if (levels[b] == 1'b0) begin
                  latched[b]   = EV_PRESS;
                  press_at[b]  = now;
                  hold_done[b] = 1'b0;
               end else begin
                  latched[b] = EV_RELEASE;
               end
            end
            // Long presses give one hold event, then repeats at the normal or fast rate.
            if (stable_lvl[b] == 1'b0 && (now - press_at[b]) > hold_ms) begin
               if (!hold_done[b]) begin
                  latched[b]   = EV_HOLD;
                  hold_done[b] = 1'b1;
                  repeat_at[b] = now;
               end
               interval = ((now - press_at[b]) > accel_ms) ? fast_ms : slow_ms;
               if ((now - repeat_at[b]) > interval) begin
                  latched[b]   = EV_REPEAT;
                  repeat_at[b] = now;
               end
            end
         end
      endfunction

      // Every event read on the way down the priority list is lost, match or not.
      function nav_type resolve_nav();
         event_type e;
         if (take_event(KEY_SELECT) == EV_PRESS) return ACT_SELECT;
         if (take_event(KEY_BACK) == EV_PRESS) return ACT_BACK;
         e = take_event(KEY_UP);
         if (e == EV_PRESS || e == EV_REPEAT) return ACT_UP;
         e = take_event(KEY_DOWN);
         if (e == EV_PRESS || e == EV_REPEAT) return ACT_DOWN;
         return ACT_IDLE;
      endfunction

      function void note_request(logic [1:0] command, logic [31:0] stamp,
                                 logic [3:0] raw, logic [1:0] index);
         button_rsp_type r;
         r.ev  = EV_NONE;
         r.nav = ACT_IDLE;
         case (command)
            CMD_TICK: sample_tick(stamp, raw);
            CMD_READ: r.ev = take_event(int'(index));
            CMD_NAV:  r.nav = resolve_nav();
            default: ;
         endcase
         for (int b = 0; b < PINS; b++)
            r.mask[b] = (stable_lvl[b] == 1'b0);
         pending_responses.push_back(r);
      endfunction

      function void check_response(logic [2:0] ev, logic [2:0] nav, logic [3:0] mask);
         button_rsp_type r;
         if (pending_responses.size() == 0) begin
            $display("%0t: response word with none expected: event %0d nav %0d mask %b",
                     $time, ev, nav, mask);
            errors++;
            return;
         end
         r = pending_responses.pop_front();
         if (ev !== r.ev) begin
            $display("%0t: event_code expected %0d, actual %0d", $time, r.ev, ev);
            errors++;
         end
         if (nav !== r.nav) begin
            $display("%0t: nav_action expected %0d, actual %0d", $time, r.nav, nav);
            errors++;
         end
         if (mask !== r.mask) begin
            $display("%0t: pressed_mask expected %b, actual %b", $time, r.mask, mask);
            errors++;
         end
      endfunction

      function int pending();
         return pending_responses.size();
      endfunction
   endclass

endpackage

FILE: dv/button_debounce_hold_repeat_tb.sv
// Self-checking testbench for button_debounce_hold_repeat: directed and random request
// words over several timing settings and idling mixes, checked word by word against
// the scoreboard in bdhr_tb_pkg. Depends on bdhr_pkg, bdhr_if and bdhr_tb_pkg.
`timescale 1ns / 1ps

module button_debounce_hold_repeat_tb;

   import bdhr_pkg::*;
   import bdhr_tb_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   bdhr_req_if req_ch ();
   bdhr_rsp_if rsp_ch ();

   debounce_scoreboard_type sb = new();

   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_off_left;
   logic [31:0] now_ms;
   logic [3:0]  level_state;
   int          dwell [PINS];

   button_debounce_hold_repeat i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Observe every handshake and register write at the edge where it takes effect.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.command, req_ch.timestamp, req_ch.raw_levels,
                            req_ch.button_index);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.event_code, rsp_ch.nav_action, rsp_ch.pressed_mask);
         if (csr_we)
            sb.write_config(csr_index, csr_wdata);
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: too long without any word moving ends the run.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_ch.valid && req_ch.ready) ||
             (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("** button_debounce_hold_repeat: FAILED **");
      $finish;
   end

   // Offer one request word after a random gap and wait until it is taken.
   task automatic send_word(input logic [1:0] command, input logic [31:0] stamp,
                            input logic [3:0] raw, input logic [1:0] index);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= command;
      req_ch.timestamp    <= stamp;
      req_ch.raw_levels   <= raw;
      req_ch.button_index <= index;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop offering and wait until every expected word has come back.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic program_timing(input logic [15:0] deb, input logic [15:0] hold,
                                 input logic [15:0] rpt, input logic [15:0] fast,
                                 input logic [15:0] accel);
      csr_we <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      csr_index <= CSR_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      csr_index <= CSR_REPEAT;
      csr_wdata <= rpt;
      @(posedge clock);
      csr_index <= CSR_FAST;
      csr_wdata <= fast;
      @(posedge clock);
      csr_index <= CSR_ACCEL;
      csr_wdata <= accel;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] random_timing();
      return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 300))
                                         : 16'($urandom_range(0, 65535));
   endfunction

   // Mostly ticks of plausible button activity (presses, long holds, chatter),
   // mixed with reads, nav queries, the unused command and fully random words.
   task automatic generate_items(input int count, input int max_step);
      int         kind;
      logic [3:0] raw;
      for (int n = 0; n < count; n++) begin
         kind = int'($urandom_range(0, 99));
         if (kind < 5) begin
            send_word(2'($urandom_range(0, 3)), 32'($urandom), 4'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
         end else if (kind < 8) begin
            send_word(CMD_UNUSED, 32'($urandom), 4'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
         end else if (kind < 72) begin
            now_ms = now_ms + 32'($urandom_range(0, max_step));
            for (int b = 0; b < PINS; b++) begin
               if (dwell[b] == 0) begin
                  level_state[b] = ~level_state[b];
                  if (level_state[b] == 1'b0)
                     dwell[b] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(30, 160))
                                                            : int'($urandom_range(1, 10));
                  else
                     dwell[b] = int'($urandom_range(1, 12));
               end else begin
                  dwell[b]--;
               end
               raw[b] = level_state[b] ^ ($urandom_range(0, 19) == 0);
            end
            send_word(CMD_TICK, now_ms, raw, 2'($urandom_range(0, 3)));
         end else if (kind < 86) begin
            send_word(CMD_READ, 32'($urandom), 4'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
         end else begin
            send_word(CMD_NAV, 32'($urandom), 4'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_DEBOUNCE;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.command      = CMD_TICK;
      req_ch.timestamp    = '0;
      req_ch.raw_levels   = 4'hF;
      req_ch.button_index = '0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      hold_off_left       = 0;
      now_ms              = '0;
      level_state         = 4'hF;
      for (int b = 0; b < PINS; b++)
         dwell[b] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed walk with reset timing: press, nav priority and discards, hold,
      // repeat, fast repeat, release, the unused command and a timestamp wrap.
      send_word(CMD_TICK, 32'd0, 4'hF, 2'd0);
      send_word(CMD_TICK, 32'd5, 4'h0, 2'd0);
      send_word(CMD_TICK, 32'd26, 4'h0, 2'd0);
      send_word(CMD_READ, 32'd0, 4'h0, 2'd0);
      send_word(CMD_NAV, 32'd0, 4'h0, 2'd0);
      send_word(CMD_NAV, 32'd0, 4'h0, 2'd0);
      send_word(CMD_NAV, 32'd0, 4'h0, 2'd0);
      send_word(CMD_TICK, 32'd600, 4'h0, 2'd0);
      send_word(CMD_NAV, 32'd0, 4'h0, 2'd0);
      send_word(CMD_TICK, 32'd800, 4'h0, 2'd0);
      send_word(CMD_NAV, 32'd0, 4'h0, 2'd0);
      send_word(CMD_TICK, 32'd2100, 4'h0, 2'd0);
      send_word(CMD_READ, 32'd0, 4'h0, 2'd1);
      send_word(CMD_READ, 32'd0, 4'h0, 2'd2);
      send_word(CMD_TICK, 32'd2105, 4'hA, 2'd0);
      send_word(CMD_TICK, 32'd2130, 4'hA, 2'd0);
      send_word(CMD_READ, 32'd0, 4'hA, 2'd3);
      send_word(CMD_UNUSED, 32'hFFFF_FFFF, 4'h0, 2'd3);
      send_word(CMD_TICK, 32'hFFFF_FFF0, 4'hF, 2'd0);
      send_word(CMD_TICK, 32'd10, 4'hF, 2'd0);
      send_word(CMD_NAV, 32'd0, 4'hF, 2'd0);
      send_word(CMD_READ, 32'd0, 4'hF, 2'd0);

      // Reset timing, no idling on either side.
      now_ms = 32'd100;
      generate_items(140, 40);
      drain_responses();

      // Short timings so holds and repeats come quickly; the sender idles.
      program_timing(16'd3, 16'd40, 16'd15, 16'd5, 16'd120);
      send_idle_pct = 54;
      now_ms = 32'($urandom);
      generate_items(140, 12);
      drain_responses();

      // All timings zero; the receiver stalls and later holds off for a long
      // stretch while words keep coming, then the sender waits for the backlog.
      program_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_idle_pct  = 0;
      recv_stall_pct = 54;
      generate_items(60, 3);
      hold_off_left = 150;
      generate_items(30, 3);
      drain_responses();
      generate_items(60, 3);
      drain_responses();

      // All timings at their maximum with large time steps; both sides idle.
      program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_idle_pct  = 37;
      recv_stall_pct = 37;
      generate_items(140, 70000);
      drain_responses();

      // Random timings, with the timestamp starting just short of the 2^32 wrap.
      program_timing(random_timing(), random_timing(), random_timing(), random_timing(),
                     random_timing());
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      now_ms = 32'hFFFF_F000;
      generate_items(140, 25);
      drain_responses();

      // Back to the reset timing, both sides idling.
      program_timing(DEBOUNCE_RST, HOLD_RST, REPEAT_RST, FAST_RST, ACCEL_RST);
      send_idle_pct  = 37;
      recv_stall_pct = 37;
      generate_items(140, 40);
      drain_responses();

      // Allow for any stray word past the pipeline latency.
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("** button_debounce_hold_repeat: PASSED **");
      else
         $display("** button_debounce_hold_repeat: FAILED **");
      $finish;
   end

endmodule

FILE: button_debounce_hold_repeat.f
hdl/bdhr_pkg.sv
hdl/bdhr_if.sv
hdl/bdhr_csr.sv
hdl/bdhr_lane.sv
hdl/button_debounce_hold_repeat.sv
dv/bdhr_tb_pkg.sv
dv/button_debounce_hold_repeat_tb.sv
